// ----- rtl/core/tfn_pkg.sv -----
package tfn_pkg;

    // Default field widths of the vertex and normal channels.
    localparam int COORD_BITS_DEF       = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int OUT_BITS             = 16;

    // Magnitude limits after the edge and cross-product range reductions.
    localparam int EDGE_BITS  = 16;
    localparam int CROSS_BITS = 30;
    localparam int NUM_AXES   = 3;

    // Range-reduced cross product, as sign and magnitude, that travels beside the square root.
    typedef struct packed {
        logic [NUM_AXES-1:0][CROSS_BITS-1:0] mag;
        logic [NUM_AXES-1:0]                 neg;
        logic                                degen;
    } t_side;

endpackage

// ----- rtl/core/tfn_vtx_if.sv -----
interface tfn_vtx_if #(
    parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  vertex0_x;
    logic signed [COORD_BITS-1:0]  vertex0_y;
    logic signed [COORD_BITS-1:0]  vertex0_z;
    logic signed [COORD_BITS-1:0]  vertex1_x;
    logic signed [COORD_BITS-1:0]  vertex1_y;
    logic signed [COORD_BITS-1:0]  vertex1_z;
    logic signed [COORD_BITS-1:0]  vertex2_x;
    logic signed [COORD_BITS-1:0]  vertex2_y;
    logic signed [COORD_BITS-1:0]  vertex2_z;

    modport source (
        output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
               vertex2_x, vertex2_y, vertex2_z,
        input  ready
    );
    modport sink (
        input  valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
               vertex2_x, vertex2_y, vertex2_z,
        output ready
    );
endinterface

// ----- rtl/core/tfn_nrm_if.sv -----
interface tfn_nrm_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tfn_pkg::OUT_BITS-1:0]  normal_x;
    logic signed [tfn_pkg::OUT_BITS-1:0]  normal_y;
    logic signed [tfn_pkg::OUT_BITS-1:0]  normal_z;
    logic                                 degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ----- rtl/core/tfn_isqrt.sv -----
module tfn_isqrt #(
    parameter int LW = 62
) (
    input  logic            i_clk,
    input  logic [LW/2-1:0] i_en,
    input  logic [LW-1:0]   i_x,
    output logic [LW/2-1:0] o_root
);
    localparam int RB   = LW / 2;
    localparam int REMW = RB + 2;

    // Stage i settles root bit RB-1-i from the next two radicand bits.
    logic [REMW-1:0] r_rem  [RB-1];
    logic [LW-1:0]   r_x    [RB-1];
    logic [RB-1:0]   r_root [RB];

    genvar i;
    generate
        for (i = 0; i < RB; i++) begin : g_stage
            logic [REMW-1:0] w_prem;
            logic [LW-1:0]   w_px;
            logic [RB-1:0]   w_proot;
            logic [REMW-1:0] w_rem;
            logic [REMW-1:0] w_trial;
            logic            w_ge;

            if (i == 0) begin : g_first
                assign w_prem  = '0;
                assign w_px    = i_x;
                assign w_proot = '0;
            end else begin : g_next
                assign w_prem  = r_rem[i-1];
                assign w_px    = r_x[i-1];
                assign w_proot = r_root[i-1];
            end

            // Bring down two bits and try the next root bit.
            assign w_rem   = {w_prem[REMW-3:0], w_px[LW-1:LW-2]};
            assign w_trial = {w_proot, 2'b01};
            assign w_ge    = (w_rem >= w_trial);

            always_ff @(posedge i_clk) begin
                if (i_en[i]) begin
                    r_root[i] <= {w_proot[RB-2:0], w_ge};
                end
            end

            if (i < RB - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en[i]) begin
                        r_rem[i] <= w_ge ? (w_rem - w_trial) : w_rem;
                        r_x[i]   <= {w_px[LW-3:0], 2'b00};
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_root[RB-1];

endmodule

// ----- rtl/core/triangle_face_normal.sv -----
// Unit face normal of one triangle. Each transfer on i_vtx carries three vertices in signed
// fixed point; each transfer on o_nrm carries the normalized cross product
// (v2-v0) x (v1-v0) in signed Q1.NORMAL_FRAC_BITS, or zero with degenerate set when the
// cross product vanishes. The block takes one triangle per cycle while the output is not
// stalled, and holds many in flight. A result passes through 55 register stages at the
// defaults after its triangle is accepted: the square root pipeline settles one root bit
// per stage and the divider pipeline one quotient bit per stage. A pipeline behind a
// stalled output still fills its empty stages before i_vtx.ready drops.
module triangle_face_normal #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tfn_vtx_if.sink    i_vtx,
    tfn_nrm_if.source  o_nrm
);
    import tfn_pkg::*;

    localparam int EW   = COORD_BITS + 1;
    localparam int EMW  = (EW > EDGE_BITS) ? EW : EDGE_BITS;
    localparam int ESHW = $clog2(EMW + 1);
    localparam int SEW  = EDGE_BITS + 1;
    localparam int PW   = 2 * SEW;
    localparam int CW   = PW + 1;
    localparam int CMW  = CW - 1;
    localparam int CSHW = $clog2(CMW + 1);
    localparam int SQW  = 2 * CROSS_BITS;
    localparam int LW   = SQW + 2;
    localparam int RB   = LW / 2;
    localparam int DV   = NORMAL_FRAC_BITS + 1;
    localparam int DW   = CROSS_BITS + NORMAL_FRAC_BITS + 1;
    localparam int QX   = (DV > OUT_BITS) ? DV : OUT_BITS;
    localparam int LIM  = 2 ** (OUT_BITS - 1) - 1;

    localparam int S_EDGE  = 0;
    localparam int S_SHIFT = 1;
    localparam int S_PROD  = 2;
    localparam int S_CROSS = 3;
    localparam int S_MAG   = 4;
    localparam int S_SQR   = 5;
    localparam int S_SUM   = 6;
    localparam int S_ROOT  = 7;
    localparam int S_DINIT = S_ROOT + RB;
    localparam int S_OUT   = S_DINIT + DV + 1;
    localparam int NST     = S_OUT + 1;

    // Per-stage valid bits and load enables; a stage loads when it is empty or moves on.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;
    logic [NST-1:0] w_en;

    genvar k;
    generate
        for (k = 0; k < NST - 1; k++) begin : g_en
            assign w_en[k] = !r_vld[k] || w_en[k+1];
        end
    endgenerate
    assign w_en[NST-1] = !r_vld[NST-1] || o_nrm.ready;
    assign n_vld       = {r_vld[NST-2:0], i_vtx.valid};
    assign i_vtx.ready = w_en[S_EDGE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int j = 0; j < NST; j++) begin
                if (w_en[j]) begin
                    r_vld[j] <= n_vld[j];
                end
            end
        end
    end

    // Edge vectors v1-v0 and v2-v0.
    logic signed [EW-1:0] r_e10 [NUM_AXES];
    logic signed [EW-1:0] r_e20 [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (w_en[S_EDGE]) begin
            r_e10[0] <= EW'(i_vtx.vertex1_x) - EW'(i_vtx.vertex0_x);
            r_e10[1] <= EW'(i_vtx.vertex1_y) - EW'(i_vtx.vertex0_y);
            r_e10[2] <= EW'(i_vtx.vertex1_z) - EW'(i_vtx.vertex0_z);
            r_e20[0] <= EW'(i_vtx.vertex2_x) - EW'(i_vtx.vertex0_x);
            r_e20[1] <= EW'(i_vtx.vertex2_y) - EW'(i_vtx.vertex0_y);
            r_e20[2] <= EW'(i_vtx.vertex2_z) - EW'(i_vtx.vertex0_z);
        end
    end

    // Bring the edge magnitudes below the multiplier range with a common shift.
    logic        [EMW-1:0]       w_em10 [NUM_AXES];
    logic        [EMW-1:0]       w_em20 [NUM_AXES];
    logic        [EMW-1:0]       w_eor;
    logic        [ESHW-1:0]      w_ebl;
    logic        [ESHW-1:0]      w_esh;
    logic signed [SEW-1:0]       n_s10  [NUM_AXES];
    logic signed [SEW-1:0]       n_s20  [NUM_AXES];
    logic signed [SEW-1:0]       r_s10  [NUM_AXES];
    logic signed [SEW-1:0]       r_s20  [NUM_AXES];

    always_comb begin
        logic [SEW-1:0] t10;
        logic [SEW-1:0] t20;
        w_eor = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            w_em10[a] = EMW'($unsigned(r_e10[a][EW-1] ? -r_e10[a] : r_e10[a]));
            w_em20[a] = EMW'($unsigned(r_e20[a][EW-1] ? -r_e20[a] : r_e20[a]));
            w_eor     = w_eor | w_em10[a] | w_em20[a];
        end
        w_ebl = '0;
        for (int j = 0; j < EMW; j++) begin
            if (w_eor[j]) begin
                w_ebl = ESHW'(j + 1);
            end
        end
        w_esh = (w_ebl > ESHW'(EDGE_BITS)) ? (w_ebl - ESHW'(EDGE_BITS)) : '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            t10      = {1'b0, EDGE_BITS'(w_em10[a] >> w_esh)};
            t20      = {1'b0, EDGE_BITS'(w_em20[a] >> w_esh)};
            n_s10[a] = r_e10[a][EW-1] ? -$signed(t10) : $signed(t10);
            n_s20[a] = r_e20[a][EW-1] ? -$signed(t20) : $signed(t20);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_SHIFT]) begin
            r_s10 <= n_s10;
            r_s20 <= n_s20;
        end
    end

    // Six partial products of the cross product.
    logic signed [PW-1:0] r_p [6];

    always_ff @(posedge i_clk) begin
        if (w_en[S_PROD]) begin
            r_p[0] <= r_s20[1] * r_s10[2];
            r_p[1] <= r_s20[2] * r_s10[1];
            r_p[2] <= r_s20[2] * r_s10[0];
            r_p[3] <= r_s20[0] * r_s10[2];
            r_p[4] <= r_s20[0] * r_s10[1];
            r_p[5] <= r_s20[1] * r_s10[0];
        end
    end

    // Cross product components.
    logic signed [CW-1:0] r_c [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (w_en[S_CROSS]) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_c[a] <= CW'(r_p[2*a]) - CW'(r_p[2*a+1]);
            end
        end
    end

    // Sign and magnitude, reduced below the squaring range with a common shift.
    logic [CMW-1:0]  w_cm [NUM_AXES];
    logic [CMW-1:0]  w_cor;
    logic [CSHW-1:0] w_cbl;
    logic [CSHW-1:0] w_csh;
    t_side           n_side;
    t_side           r_side [S_MAG:S_DINIT-1];

    always_comb begin
        w_cor = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            w_cm[a] = CMW'($unsigned(r_c[a][CW-1] ? -r_c[a] : r_c[a]));
            w_cor   = w_cor | w_cm[a];
        end
        w_cbl = '0;
        for (int j = 0; j < CMW; j++) begin
            if (w_cor[j]) begin
                w_cbl = CSHW'(j + 1);
            end
        end
        w_csh = (w_cbl > CSHW'(CROSS_BITS)) ? (w_cbl - CSHW'(CROSS_BITS)) : '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            n_side.mag[a] = CROSS_BITS'(w_cm[a] >> w_csh);
            n_side.neg[a] = r_c[a][CW-1];
        end
        n_side.degen = ~|w_cor;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_MAG]) begin
            r_side[S_MAG] <= n_side;
        end
    end

    // The reduced components travel alongside the length and root stages.
    generate
        for (k = S_MAG + 1; k < S_DINIT; k++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    endgenerate

    // Squared components and their sum.
    logic [SQW-1:0] r_sq [NUM_AXES];
    logic [LW-1:0]  r_len2;

    always_ff @(posedge i_clk) begin
        if (w_en[S_SQR]) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_sq[a] <= r_side[S_MAG].mag[a] * r_side[S_MAG].mag[a];
            end
        end
        if (w_en[S_SUM]) begin
            r_len2 <= LW'(r_sq[0]) + LW'(r_sq[1]) + LW'(r_sq[2]);
        end
    end

    // Integer square root of the squared length.
    logic [RB-1:0] w_root;

    tfn_isqrt #(
        .LW (LW)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en[S_ROOT +: RB]),
        .i_x    (r_len2),
        .o_root (w_root)
    );

    // Divider pipeline: rounded quotient of each magnitude scaled by the fraction bits.
    logic [DW-1:0]       r_drem [DV][NUM_AXES];
    logic [RB-1:0]       r_ds   [DV];
    logic [DV-1:0]       r_q    [DV+1][NUM_AXES];
    logic [NUM_AXES-1:0] r_dneg [DV+1];
    logic                r_ddeg [DV+1];

    always_ff @(posedge i_clk) begin
        if (w_en[S_DINIT]) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_drem[0][a] <= {1'b0, r_side[S_DINIT-1].mag[a], NORMAL_FRAC_BITS'(0)}
                              + DW'(w_root >> 1);
                r_q[0][a]    <= '0;
            end
            r_ds[0]   <= w_root;
            r_dneg[0] <= r_side[S_DINIT-1].neg;
            r_ddeg[0] <= r_side[S_DINIT-1].degen;
        end
    end

    generate
        for (k = 1; k <= DV; k++) begin : g_div
            localparam int B = DV - k;
            logic [DW-1:0] w_trial;
            logic [NUM_AXES-1:0] w_ge;

            assign w_trial = DW'(r_ds[k-1]) << B;

            always_comb begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    w_ge[a] = (r_drem[k-1][a] >= w_trial);
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en[S_DINIT+k]) begin
                    for (int a = 0; a < NUM_AXES; a++) begin
                        r_q[k][a] <= r_q[k-1][a] | (DV'(w_ge[a]) << B);
                    end
                    r_dneg[k] <= r_dneg[k-1];
                    r_ddeg[k] <= r_ddeg[k-1];
                end
            end

            if (k < DV) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (w_en[S_DINIT+k]) begin
                        for (int a = 0; a < NUM_AXES; a++) begin
                            r_drem[k][a] <= w_ge[a] ? (r_drem[k-1][a] - w_trial)
                                                    : r_drem[k-1][a];
                        end
                        r_ds[k] <= r_ds[k-1];
                    end
                end
            end
        end
    endgenerate

    // Output register: saturate, apply the sign, zero a degenerate triangle.
    logic signed [OUT_BITS-1:0] n_out [NUM_AXES];
    logic signed [OUT_BITS-1:0] r_out [NUM_AXES];
    logic                       r_deg;

    always_comb begin
        logic [QX-1:0]       qx;
        logic [OUT_BITS-1:0] qs;
        for (int a = 0; a < NUM_AXES; a++) begin
            qx = QX'(r_q[DV][a]);
            qs = (qx > QX'(LIM)) ? OUT_BITS'(LIM) : OUT_BITS'(qx);
            if (r_ddeg[DV]) begin
                n_out[a] = '0;
            end else begin
                n_out[a] = r_dneg[DV][a] ? -$signed(qs) : $signed(qs);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_OUT]) begin
            r_out <= n_out;
            r_deg <= r_ddeg[DV];
        end
    end

    assign o_nrm.valid      = r_vld[S_OUT];
    assign o_nrm.normal_x   = r_out[0];
    assign o_nrm.normal_y   = r_out[1];
    assign o_nrm.normal_z   = r_out[2];
    assign o_nrm.degenerate = r_deg;

    // A degenerate result carries the zero vector.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nrm.valid && o_nrm.degenerate |->
            o_nrm.normal_x == '0 && o_nrm.normal_y == '0 && o_nrm.normal_z == '0)
        else $error("degenerate result with nonzero normal");

    // A proper normal always has a nonzero component.
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nrm.valid && !o_nrm.degenerate |->
            o_nrm.normal_x != '0 || o_nrm.normal_y != '0 || o_nrm.normal_z != '0)
        else $error("non-degenerate result with zero normal");

    // A full pipeline behind a stalled output takes no new triangle.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !o_nrm.ready |-> !i_vtx.ready)
        else $error("input taken while pipeline is full and stalled");

    // An accepted triangle occupies the first stage on the next cycle.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vtx.valid && i_vtx.ready |=> r_vld[S_EDGE])
        else $error("accepted triangle lost at the first stage");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    logic i_clk;
    logic i_rst_n;

    tfn_vtx_if vtx ();
    tfn_nrm_if nrm ();

    triangle_face_normal dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx.sink),
        .o_nrm   (nrm.source)
    );

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               degen;
    } t_normal;

    // Ring of expected normals, written at each input transfer and read at each result.
    t_normal exp_mem [256];
    int      exp_wr;
    int      exp_rd;
    int      err_count;
    int      cycle_count;
    bit      hold_off;

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Magnitude of a signed value.
    function automatic longint unsigned mag(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint shift_mag(input longint v, input int sh);
        longint m;
        m = longint'(mag(v) >> sh);
        return (v < 0) ? -m : m;
    endfunction

    // Integer square root, floor.
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Unit normal of the triangle in Q1.14.
    function automatic t_normal face_normal(input logic signed [8:0][15:0] c);
        longint          p[9];
        longint          e1[3];
        longint          e2[3];
        longint          n[3];
        longint unsigned mx;
        longint unsigned len2;
        longint unsigned s;
        longint unsigned q;
        longint          sq;
        int              sh;
        t_normal         r;
        for (int i = 0; i < 9; i++) p[i] = longint'($signed(c[i]));
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            e1[i] = p[3+i] - p[i];
            e2[i] = p[6+i] - p[i];
            if (mag(e1[i]) > mx) mx = mag(e1[i]);
            if (mag(e2[i]) > mx) mx = mag(e2[i]);
        end
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 16)) sh++;
        for (int i = 0; i < 3; i++) begin
            e1[i] = shift_mag(e1[i], sh);
            e2[i] = shift_mag(e2[i], sh);
        end
        n[0] = e2[1] * e1[2] - e2[2] * e1[1];
        n[1] = e2[2] * e1[0] - e2[0] * e1[2];
        n[2] = e2[0] * e1[1] - e2[1] * e1[0];
        mx = 0;
        for (int i = 0; i < 3; i++) if (mag(n[i]) > mx) mx = mag(n[i]);
        r = '0;
        if (mx == 0) begin
            r.degen = 1'b1;
            return r;
        end
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 30)) sh++;
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            n[i] = shift_mag(n[i], sh);
            len2 += mag(n[i]) * mag(n[i]);
        end
        s = floor_sqrt(len2);
        for (int i = 0; i < 3; i++) begin
            q = ((mag(n[i]) << 14) + (s >> 1)) / s;
            if (q > 32767) q = 32767;
            sq = (n[i] < 0) ? -longint'(q) : longint'(q);
            if (i == 0) r.nx = sq[15:0];
            else if (i == 1) r.ny = sq[15:0];
            else r.nz = sq[15:0];
        end
        return r;
    endfunction

    task automatic report(input string what, input string detail);
        $display("ERROR %s: %s at cycle %0d", what, detail, cycle_count);
        err_count++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Sends one triangle and records its expected normal.
    task automatic send_triangle(input logic signed [8:0][15:0] c, input bit idle);
        int g;
        g = idle ? gap_len() : 0;
        if (g > 0) begin
            vtx.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        vtx.valid     <= 1'b1;
        vtx.vertex0_x <= c[0];
        vtx.vertex0_y <= c[1];
        vtx.vertex0_z <= c[2];
        vtx.vertex1_x <= c[3];
        vtx.vertex1_y <= c[4];
        vtx.vertex1_z <= c[5];
        vtx.vertex2_x <= c[6];
        vtx.vertex2_y <= c[7];
        vtx.vertex2_z <= c[8];
        @(posedge i_clk);
        while (!vtx.ready) @(posedge i_clk);
        exp_mem[exp_wr % 256] = face_normal(c);
        exp_wr++;
    endtask

    task automatic end_burst();
        vtx.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    // Extremes, degenerate shapes and axis-aligned triangles.
    task automatic test_directed();
        logic signed [8:0][15:0] c;
        c = '0;
        send_triangle(c, 1'b0);
        c = {9{16'sh7fff}};
        send_triangle(c, 1'b0);
        c = {16'sh0200, 16'sh0200, 16'sh0200, 16'sh0100, 16'sh0100, 16'sh0100, 48'h0};
        send_triangle(c, 1'b0);
        c = {16'h0, 16'sh0100, 16'h0, 16'h0, 16'h0, 16'sh0100, 48'h0};
        send_triangle(c, 1'b0);
        c = {16'sh0100, 16'h0, 16'h0, 16'h0, 16'sh0100, 16'h0, 48'h0};
        send_triangle(c, 1'b0);
        c = {16'h0, 16'h0, 16'sh0100, 16'h0, 16'sh0100, 16'h0, 48'h0};
        send_triangle(c, 1'b0);
        c = {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
             16'sh8000, 16'sh8000, 16'sh8000};
        send_triangle(c, 1'b0);
        c = {16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
             16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_triangle(c, 1'b0);
        c = {16'sh8000, 16'sh7fff, 16'h0, 16'sh7fff, 16'h0, 16'sh8000,
             16'h0, 16'sh8000, 16'sh7fff};
        send_triangle(c, 1'b0);
        c = {16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'hffff, 16'hffff, 16'hffff};
        send_triangle(c, 1'b0);
        c = {16'hffff, 16'h0001, 16'h0003, 16'h0002, 16'hfffe, 16'h0005, 48'h0};
        send_triangle(c, 1'b0);
        c = {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
             16'h5555, 16'haaaa, 16'h5555};
        send_triangle(c, 1'b0);
        end_burst();
    endtask

    // Random triangles, with some collinear ones among them.
    task automatic test_random(input int count);
        logic signed [8:0][15:0] c;
        int                      k;
        for (int t = 0; t < count; t++) begin
            for (int i = 0; i < 9; i++) c[i] = rand_coord();
            if ($urandom_range(0, 9) == 0) begin
                k = $urandom_range(1, 3);
                for (int i = 0; i < 3; i++)
                    c[6+i] = 16'(c[i] + k * (c[3+i] - c[i]));
            end
            send_triangle(c, 1'b1);
        end
        end_burst();
    endtask

    // Back-to-back items against a long output hold-off.
    task automatic test_backpressure();
        logic signed [8:0][15:0] c;
        hold_off = 1'b1;
        for (int t = 0; t < 150; t++) begin
            for (int i = 0; i < 9; i++) c[i] = 16'($urandom);
            send_triangle(c, 1'b0);
        end
        end_burst();
    endtask

    // Receiver readiness: a long hold-off when asked, otherwise random stalls.
    initial begin
        int stall;
        nrm.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                nrm.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            stall = gap_len();
            if (stall > 0) begin
                nrm.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            nrm.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    // Checks each transfer on the output against the oldest expectation.
    always @(posedge i_clk) begin
        t_normal want;
        if (i_rst_n && nrm.valid && nrm.ready) begin
            if (exp_rd == exp_wr) begin
                report("unexpected", "result with nothing expected");
            end else begin
                want = exp_mem[exp_rd % 256];
                exp_rd++;
                if (nrm.normal_x !== want.nx)
                    report("normal_x", $sformatf("got %0d want %0d", nrm.normal_x, want.nx));
                if (nrm.normal_y !== want.ny)
                    report("normal_y", $sformatf("got %0d want %0d", nrm.normal_y, want.ny));
                if (nrm.normal_z !== want.nz)
                    report("normal_z", $sformatf("got %0d want %0d", nrm.normal_z, want.nz));
                if (nrm.degenerate !== want.degen)
                    report("degenerate", $sformatf("got %0b want %0b",
                           nrm.degenerate, want.degen));
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 500000) begin
            $display("triangle_face_normal: mismatch");
            $finish;
        end
    end

    initial begin
        err_count    = 0;
        cycle_count  = 0;
        exp_wr       = 0;
        exp_rd       = 0;
        hold_off     = 1'b0;
        i_rst_n       <= 1'b0;
        vtx.valid     <= 1'b0;
        vtx.vertex0_x <= '0;
        vtx.vertex0_y <= '0;
        vtx.vertex0_z <= '0;
        vtx.vertex1_x <= '0;
        vtx.vertex1_y <= '0;
        vtx.vertex1_z <= '0;
        vtx.vertex2_x <= '0;
        vtx.vertex2_y <= '0;
        vtx.vertex2_z <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(840);
        while (exp_rd != exp_wr) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (err_count == 0) begin
            $display("triangle_face_normal: match");
        end else begin
            $display("triangle_face_normal: mismatch");
        end
        $finish;
    end

endmodule
